[hw/rtl/mmf_pkg.sv]
// shared types and constants for the fixed-point matrix multiplier
package mmf_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;
  localparam int VALUE_W = 16;
  localparam int ACC_W   = 36;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  // item commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULT   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } mmf_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] product;
    logic                    last;
    logic                    dims_error;
  } mmf_out_t;

  // per-cycle control broadcast to every mac cell
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
    logic shift_en;
  } mmf_cell_ctl_t;

endpackage

[hw/rtl/mmf_stores.sv]
// element stores for both matrices with per-entry valid bits
module mmf_stores #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int DIM_W      = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_a,
  input  logic                                wr_b,
  input  logic [DIM_W-1:0]                    wr_row,
  input  logic [DIM_W-1:0]                    wr_col,
  input  logic [ELEM_WIDTH-1:0]               wr_val,
  input  logic [DIM_W-1:0]                    rd_row,
  input  logic [DIM_W-1:0]                    rd_k,
  output logic [ELEM_WIDTH-1:0]               a_elem,
  output logic [MAX_DIM-1:0][ELEM_WIDTH-1:0]  b_row
);
  import mmf_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ELEM_WIDTH-1:0]              a_mem [DEPTH];
  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] b_mem [MAX_DIM];
  logic [DEPTH-1:0]                   a_vld_r;
  logic [MAX_DIM-1:0]                 b_vld_r [MAX_DIM];

  logic [ELEM_WIDTH-1:0]              a_rd_r;
  logic                               a_hit_r;
  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] b_rd_r;
  logic [MAX_DIM-1:0]                 b_hit_r;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(wr_row * MAX_DIM) + ADDR_W'(wr_col);
  assign rd_addr = ADDR_W'(rd_row * MAX_DIM) + ADDR_W'(rd_k);

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      for (int r = 0; r < MAX_DIM; r++) begin
        b_vld_r[r] <= '0;
      end
    end else begin
      if (wr_a) begin
        a_vld_r[wr_addr] <= 1'b1;
      end
      if (wr_b) begin
        b_vld_r[wr_row][wr_col] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= wr_val;
    end
    if (wr_b) begin
      b_mem[wr_row][wr_col] <= wr_val;
    end
    a_rd_r  <= a_mem[rd_addr];
    a_hit_r <= a_vld_r[rd_addr];
    b_rd_r  <= b_mem[rd_k];
    b_hit_r <= b_vld_r[rd_k];
  end

  assign a_elem = a_hit_r ? a_rd_r : '0;

  always_comb begin
    for (int j = 0; j < MAX_DIM; j++) begin
      b_row[j] = b_hit_r[j] ? b_rd_r[j] : '0;
    end
  end

endmodule

[hw/rtl/mmf_mac_cell.sv]
// one multiply-accumulate cell of the output-row chain
module mmf_mac_cell #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  mmf_pkg::mmf_cell_ctl_t        ctl,
  input  logic signed [ELEM_WIDTH-1:0]  a,
  input  logic signed [ELEM_WIDTH-1:0]  b,
  input  logic signed [mmf_pkg::ACC_W-1:0] shift_in,
  output logic signed [mmf_pkg::ACC_W-1:0] acc_out
);
  import mmf_pkg::*;

  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  // sign-extend, then wrap to the accumulator width
  assign prod_ext = ACC_W'(64'(prod_r));

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= a * b;
    end
    if (ctl.shift_en) begin
      acc_r <= shift_in;
    end else if (ctl.acc_en) begin
      acc_r <= ctl.acc_first ? prod_ext : acc_r + prod_ext;
    end
  end

  assign acc_out = acc_r;

endmodule

[hw/rtl/matrix_multiply_fixed.sv]
// top level: fixed-point matrix multiplier built on a chain of mac cells
// load items are taken only while the sequencer is idle; a multiply item works row by row:
// the cells take A[i][k] and row k of B for each k, through the store read and product registers,
// then the row's sums shift out of the chain whenever the output slot is free
// synchronous active-low reset clears both stores' valid bits and sets all sizes to 8
module matrix_multiply_fixed #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mmf_pkg::mmf_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mmf_pkg::mmf_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mmf_pkg::CFG_W-1:0]         cfg_wdata
);
  import mmf_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  // size register as used: zero acts as one, too large acts as the maximum
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] s;
    if (v == '0) begin
      s = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      s = CNT_W'(MAX_DIM);
    end else begin
      s = CNT_W'(v);
    end
    return s;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= CFG_RESET;
      cols_a_r <= CFG_RESET;
      rows_b_r <= CFG_RESET;
      cols_b_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS_A: rows_a_r <= cfg_wdata;
        REG_COLS_A: cols_a_r <= cfg_wdata;
        REG_ROWS_B: rows_b_r <= cfg_wdata;
        REG_COLS_B: cols_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] eff_ra, eff_ca, eff_rb, eff_cb;

  assign eff_ra = eff_size(rows_a_r);
  assign eff_ca = eff_size(cols_a_r);
  assign eff_rb = eff_size(rows_b_r);
  assign eff_cb = eff_size(cols_b_r);

  // sequencer and pipeline control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] d_r, d_nxt;

  logic rd_vld_r, rd_first_r, rd_last_r;
  logic mul_vld_r, mul_first_r, mul_last_r;

  logic     out_vld_r, out_vld_nxt;
  mmf_out_t out_data_r, out_data_nxt;

  logic in_fire;
  logic slot_free;
  logic issue;
  logic issue_first;
  logic issue_last;
  logic load_a_ok;
  logic load_b_ok;
  logic row_last;
  logic col_last;

  mmf_cell_ctl_t cell_ctl;

  logic signed [ACC_W-1:0] acc_q [MAX_DIM];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_vld_r || out_ready;

  // a load outside the configured size is dropped
  assign load_a_ok = in_fire && (in_data.cmd == CMD_LOAD_A)
                     && (32'(in_data.row) < 32'(eff_ra))
                     && (32'(in_data.col) < 32'(eff_ca));
  assign load_b_ok = in_fire && (in_data.cmd == CMD_LOAD_B)
                     && (32'(in_data.row) < 32'(eff_rb))
                     && (32'(in_data.col) < 32'(eff_cb));

  assign issue       = (state_r == ST_RUN);
  assign issue_first = (k_r == '0);
  assign issue_last  = (k_r == eff_ca - CNT_W'(1));
  assign row_last    = (i_r == eff_ra - CNT_W'(1));
  assign col_last    = (d_r == eff_cb - CNT_W'(1));

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    d_nxt        = d_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_data_nxt = out_data_r;
    cell_ctl.mul_en    = rd_vld_r;
    cell_ctl.acc_en    = mul_vld_r;
    cell_ctl.acc_first = mul_first_r;
    cell_ctl.shift_en  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.cmd == CMD_MULT)) begin
          i_nxt = '0;
          k_nxt = '0;
          d_nxt = '0;
          if (eff_ca != eff_rb) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        k_nxt = k_r + CNT_W'(1);
        if (issue_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last partial product lands in the accumulators at this edge
        if (mul_vld_r && mul_last_r) begin
          d_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          cell_ctl.shift_en       = 1'b1;
          out_vld_nxt             = 1'b1;
          out_data_nxt.out_row    = IDX_W'(i_r);
          out_data_nxt.out_col    = IDX_W'(d_r);
          out_data_nxt.product    = acc_q[0];
          out_data_nxt.last       = row_last && col_last;
          out_data_nxt.dims_error = 1'b0;
          d_nxt                   = d_r + CNT_W'(1);
          if (col_last) begin
            if (row_last) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + CNT_W'(1);
              k_nxt     = '0;
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_vld_nxt             = 1'b1;
          out_data_nxt.out_row    = '0;
          out_data_nxt.out_col    = '0;
          out_data_nxt.product    = '0;
          out_data_nxt.last       = 1'b1;
          out_data_nxt.dims_error = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      i_r       <= '0;
      k_r       <= '0;
      d_r       <= '0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      k_r       <= k_nxt;
      d_r       <= d_nxt;
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      out_vld_r <= out_vld_nxt;
    end
  end

  // pipeline tags and output payload carry no reset
  always_ff @(posedge clk) begin
    rd_first_r  <= issue_first;
    rd_last_r   <= issue_last;
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // element stores: A read one element a cycle, B read one row a cycle
  logic [ELEM_WIDTH-1:0]              a_elem;
  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] b_row;

  mmf_stores #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .DIM_W      (DIM_W)
  ) u_stores (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_a   (load_a_ok),
    .wr_b   (load_b_ok),
    .wr_row (in_data.row[DIM_W-1:0]),
    .wr_col (in_data.col[DIM_W-1:0]),
    .wr_val (ELEM_WIDTH'($unsigned(in_data.value))),
    .rd_row (i_r[DIM_W-1:0]),
    .rd_k   (k_r[DIM_W-1:0]),
    .a_elem (a_elem),
    .b_row  (b_row)
  );

  // chain of cells: cell j owns output column j of the current row,
  // and during drain each cell hands its sum to the neighbor below
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic signed [ACC_W-1:0] chain_in;

    if (j == MAX_DIM - 1) begin : g_tail
      assign chain_in = '0;
    end else begin : g_link
      assign chain_in = acc_q[j+1];
    end

    mmf_mac_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .a        ($signed(a_elem)),
      .b        ($signed(b_row[j])),
      .shift_in (chain_in),
      .acc_out  (acc_q[j])
    );
  end

endmodule

[tb/sv/matrix_multiply_fixed_checker.sv]
// result checker for the fixed-point matrix multiplier: predicts products and compares them
`timescale 1ns / 100ps

module matrix_multiply_fixed_checker #(
  parameter int MAX_DIM = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  mmf_pkg::mmf_in_t      in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  mmf_pkg::mmf_out_t     out_data,
  input  logic                  cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  import mmf_pkg::*;

  logic signed [VALUE_W-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] mat_b [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0]          size_reg [4];
  mmf_out_t                  product_q [$];
  int                        mismatches = 0;

  // zero reads as one, anything past the array size reads as the array size
  function automatic int dim_of(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // queues every element of a times b, or one error result
  task automatic multiply_stores();
    int       ra, ca, rb, cb;
    longint   sum;
    mmf_out_t res;
    ra = dim_of(size_reg[REG_ROWS_A]);
    ca = dim_of(size_reg[REG_COLS_A]);
    rb = dim_of(size_reg[REG_ROWS_B]);
    cb = dim_of(size_reg[REG_COLS_B]);
    res = '0;
    if (ca != rb) begin
      res.last = 1'b1;
      res.dims_error = 1'b1;
      product_q.push_back(res);
      return;
    end
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        sum = 0;
        for (int k = 0; k < ca; k++)
          sum += longint'(mat_a[i*MAX_DIM+k]) * longint'(mat_b[k*MAX_DIM+j]);
        res.out_row    = IDX_W'(i);
        res.out_col    = IDX_W'(j);
        res.product    = sum[ACC_W-1:0];
        res.last       = (i == ra - 1) && (j == cb - 1);
        res.dims_error = 1'b0;
        product_q.push_back(res);
      end
    end
  endtask

  task automatic apply_item(input mmf_in_t item);
    int pos;
    pos = int'(item.row) * MAX_DIM + int'(item.col);
    case (item.cmd)
      CMD_LOAD_A: begin
        if (item.row < dim_of(size_reg[REG_ROWS_A]) && item.col < dim_of(size_reg[REG_COLS_A]))
          mat_a[pos] = item.value;
      end
      CMD_LOAD_B: begin
        if (item.row < dim_of(size_reg[REG_ROWS_B]) && item.col < dim_of(size_reg[REG_COLS_B]))
          mat_b[pos] = item.value;
      end
      CMD_MULT: begin
        multiply_stores();
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input mmf_out_t got);
    mmf_out_t want;
    if (product_q.size() == 0) begin
      report_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                got.out_row, got.out_col));
      return;
    end
    want = product_q.pop_front();
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report_mismatch($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
    if (got.product !== want.product)
      report_mismatch($sformatf("product (%0d,%0d) %0d, expected %0d",
                                want.out_row, want.out_col, got.product, want.product));
    if (got.last !== want.last)
      report_mismatch($sformatf("last (%0d,%0d) %b, expected %b",
                                want.out_row, want.out_col, got.last, want.last));
    if (got.dims_error !== want.dims_error)
      report_mismatch($sformatf("dims_error %b, expected %b", got.dims_error, want.dims_error));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (mat_a[n]) begin
        mat_a[n] = '0;
        mat_b[n] = '0;
      end
      foreach (size_reg[n]) size_reg[n] = CFG_RESET;
      product_q.delete();
    end else begin
      if (cfg_we) size_reg[cfg_idx] = cfg_wdata;
      if (in_valid && in_ready) apply_item(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    fail_count <= mismatches;
    pending    <= product_q.size();
  end

endmodule

[tb/sv/matrix_multiply_fixed_tb.sv]
// testbench top for the fixed-point matrix multiplier: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module matrix_multiply_fixed_tb;
  import mmf_pkg::*;

  localparam int MAX_DIM         = 8;
  localparam int ITEMS_PER_PHASE = 100;
  // quiet spell after the last expected product at the end of the run
  localparam int TAIL_CYCLES     = 150;
  // a short pause after the products drain covers any item still in flight
  localparam int SETTLE_CYCLES   = 16;
  localparam int STALL_LIMIT     = 4000;
  // cmd value with no function, must be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  mmf_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mmf_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int mismatch_count;
  int pending_results;

  // percent of cycles in which each side holds off
  int send_idle = 12;
  int recv_idle = 63;

  // effective sizes the random stimulus is built around
  int ra, ca, rb, cb;
  // loads that land in a store plus multiplies
  int work_items;

  matrix_multiply_fixed uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  matrix_multiply_fixed_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (mismatch_count),
    .pending    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // element values lean toward the corners of q8.8
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return VALUE_W'($urandom_range(16'hffff));
    endcase
  endfunction

  // small sizes mostly, the full array now and then
  function automatic int pick_dim();
    if ($urandom_range(99) < 15) return MAX_DIM;
    return $urandom_range(4, 1);
  endfunction

  // the wanted size, sometimes as an out-of-range encoding that still means it
  function automatic logic [CFG_W-1:0] encode_dim(input int d);
    if (d == 1 && $urandom_range(3) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(1) == 0) return CFG_W'($urandom_range(15, 9));
    return CFG_W'(d);
  endfunction

  // holds the item until the block takes it; valid stays up afterwards
  task automatic send_item(input logic [CMD_W-1:0] cmd, input int r, input int c,
                           input logic [VALUE_W-1:0] v);
    mmf_in_t item;
    item.cmd   = cmd;
    item.row   = IDX_W'(r);
    item.col   = IDX_W'(c);
    item.value = v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // block has given every expected product, then a short quiet spell
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_sizes(input logic [CFG_W-1:0] r_ra, input logic [CFG_W-1:0] r_ca,
                             input logic [CFG_W-1:0] r_rb, input logic [CFG_W-1:0] r_cb);
    write_reg(REG_ROWS_A, r_ra);
    write_reg(REG_COLS_A, r_ca);
    write_reg(REG_ROWS_B, r_rb);
    write_reg(REG_COLS_B, r_cb);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(input int nra, input int nca, input int nrb, input int ncb);
    write_sizes(encode_dim(nra), encode_dim(nca), encode_dim(nrb), encode_dim(ncb));
    ra = nra;
    ca = nca;
    rb = nrb;
    cb = ncb;
  endtask

  // a load or unused command anywhere in the index space, mostly ignored
  task automatic send_noise();
    logic [CMD_W-1:0] cmd;
    int               r, c;
    case ($urandom_range(2))
      0: cmd = CMD_LOAD_A;
      1: cmd = CMD_LOAD_B;
      default: cmd = CMD_UNUSED;
    endcase
    r = $urandom_range(7);
    c = $urandom_range(7);
    send_item(cmd, r, c, rand_value());
    if ((cmd == CMD_LOAD_A && r < ra && c < ca) || (cmd == CMD_LOAD_B && r < rb && c < cb))
      work_items++;
  endtask

  // optional resize, fill most of both matrices, a little noise, then multiply
  task automatic run_sequence(input bit resize);
    int inner;
    if (resize) begin
      wait_drained(SETTLE_CYCLES);
      inner = pick_dim();
      // inner sizes usually agree, otherwise the multiply reports an error
      set_sizes(pick_dim(), inner, ($urandom_range(99) < 85) ? inner : pick_dim(), pick_dim());
    end
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < ca; j++) begin
        if ($urandom_range(3) != 0) begin
          send_item(CMD_LOAD_A, i, j, rand_value());
          work_items++;
        end
      end
    end
    for (int i = 0; i < rb; i++) begin
      for (int j = 0; j < cb; j++) begin
        if ($urandom_range(3) != 0) begin
          send_item(CMD_LOAD_B, i, j, rand_value());
          work_items++;
        end
      end
    end
    repeat ($urandom_range(2)) send_noise();
    // row, col and value mean nothing on a multiply, so they are random
    send_item(CMD_MULT, $urandom_range(7), $urandom_range(7), rand_value());
    work_items++;
    if ($urandom_range(5) == 0) begin
      send_item(CMD_MULT, $urandom_range(7), $urandom_range(7), rand_value());
      work_items++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes on cleared stores: 64 zero products
    send_item(CMD_MULT, 0, 0, 16'h0000);

    // extreme elements at the corners plus two inner elements, an unused command in between
    send_item(CMD_LOAD_A, 0, 0, 16'h8000);
    send_item(CMD_LOAD_A, 7, 7, 16'h7fff);
    send_item(CMD_LOAD_A, 3, 5, 16'hffff);
    send_item(CMD_LOAD_B, 0, 0, 16'h8000);
    send_item(CMD_LOAD_B, 7, 7, 16'h7fff);
    send_item(CMD_UNUSED, 7, 7, 16'h7fff);
    send_item(CMD_LOAD_B, 5, 2, 16'h0100);
    send_item(CMD_MULT, 7, 7, 16'hffff);
    wait_drained(SETTLE_CYCLES);

    // zero acts as one, nine and fifteen act as eight: 1x8 times 8x1
    write_sizes(4'd0, 4'd9, 4'd15, 4'd0);
    send_item(CMD_LOAD_A, 1, 0, 16'h7fff);
    send_item(CMD_LOAD_B, 0, 1, 16'h7fff);
    send_item(CMD_LOAD_A, 0, 7, 16'h7fff);
    send_item(CMD_MULT, 0, 0, 16'h0000);
    wait_drained(SETTLE_CYCLES);

    // outer product, 8x1 times 1x8
    write_sizes(4'd15, 4'd0, 4'd0, 4'd15);
    send_item(CMD_LOAD_B, 0, 7, 16'h8000);
    send_item(CMD_MULT, 0, 0, 16'h0000);
    wait_drained(SETTLE_CYCLES);

    // inner sizes differ: single error result
    write_sizes(4'd2, 4'd3, 4'd4, 4'd2);
    send_item(CMD_MULT, 0, 0, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 12;
          recv_idle = 63;
        end
        1: begin
          send_idle = 63;
          recv_idle = 12;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      work_items = 0;
      run_sequence(1'b1);
      while (work_items < ITEMS_PER_PHASE) run_sequence($urandom_range(2) == 0);
    end

    wait_drained(TAIL_CYCLES);
    @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ends a run in which neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mmf_pkg.sv
hw/rtl/mmf_stores.sv
hw/rtl/mmf_mac_cell.sv
hw/rtl/matrix_multiply_fixed.sv
tb/sv/matrix_multiply_fixed_checker.sv
tb/sv/matrix_multiply_fixed_tb.sv
